[rtl/supply_and_input_supervisor_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the supply and input supervisor
// Clocked property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_AND_INPUT_SUPERVISOR_ASSERT_SVH
`define SUPPLY_AND_INPUT_SUPERVISOR_ASSERT_SVH

// Checked while out of reset.
`define SIS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants and types of the supply and input supervisor.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int ADC_BITS_DEF      = 12;
   localparam int DEBOUNCE_BITS_DEF = 16;

   localparam int NUM_CH       = 5;
   localparam int FIVE_VOLT_CH = 2;

   localparam int THR_REG_W  = 24;
   localparam int RELOAD_W   = 16;
   localparam int RTC_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_THR      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BATTERY_THR   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FIVE_VOLT_THR = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_RELAY_SUP_THR = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MAIN_SUP_THR  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_EXT_MODE      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_DEB_RELOADS   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_SERVICE_DL    = 3'd7;

   // result field bit positions
   localparam int RSP_EXT_CMD      = 5;
   localparam int RSP_RELAY_AC_ON  = 6;
   localparam int RSP_RELAY_DC_ON  = 7;
   localparam int RSP_RELAY_AC_ERR = 8;
   localparam int RSP_RELAY_DC_ERR = 9;
   localparam int RSP_NEED_SERVICE = 10;
   localparam int RSP_FIELD_W      = 11;
   localparam int RSP_TDATA_W      = 16;

   typedef struct packed {
      logic                mode;          // 1: enable mode reload
      logic [RELOAD_W-1:0] reload_start;
      logic [RELOAD_W-1:0] reload_enable;
   } dbn_cfg_type;

endpackage

[rtl/sis_chan_mon.sv]
// ----------------------------------------------------------------------------
// sis_chan_mon
// One supervised ADC channel: fail flag with trip/release hysteresis.
// ----------------------------------------------------------------------------
module sis_chan_mon #(
   parameter int ADC_BITS = sis_pkg::ADC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  logic [ADC_BITS-1:0] code,
   input  logic [ADC_BITS-1:0] trip,
   input  logic [ADC_BITS-1:0] release_code,
   output logic                fail_next
);

   logic fail_ff;
   logic fail_in;

   // failed channel clears at/above release, clear channel trips below trip
   always_comb begin
      if (fail_ff) begin
         fail_in = !(code >= release_code);
      end else begin
         fail_in = (code < trip);
      end
   end

   assign fail_next = fail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff <= 1'b0;
      end else if (update) begin
         fail_ff <= fail_in;
      end
   end

endmodule

[rtl/sis_debounce.sv]
// ----------------------------------------------------------------------------
// sis_debounce
// Switch debouncer with mode-selected reload, frozen when not enabled.
// ----------------------------------------------------------------------------
module sis_debounce #(
   parameter int DEBOUNCE_BITS = sis_pkg::DEBOUNCE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  logic                switch_active,
   input  sis_pkg::dbn_cfg_type cfg,
   output logic                cmd_next
);

   logic                     cmd_ff;
   logic                     cmd_in;
   logic                     prev_ff;
   logic [DEBOUNCE_BITS-1:0] count_ff;
   logic [DEBOUNCE_BITS-1:0] count_in;
   logic [sis_pkg::RELOAD_W-1:0] reload_sel;
   logic [2*sis_pkg::RELOAD_W-1:0] reload_ext;

   assign reload_sel = cfg.mode ? cfg.reload_enable : cfg.reload_start;
   assign reload_ext = {{sis_pkg::RELOAD_W{1'b0}}, reload_sel};

   always_comb begin
      cmd_in   = cmd_ff;
      count_in = count_ff;
      if (update) begin
         if (prev_ff == switch_active) begin
            if (count_ff == '0) begin
               cmd_in = switch_active;
            end else begin
               count_in = count_ff - DEBOUNCE_BITS'(1);
            end
         end else begin
            count_in = reload_ext[DEBOUNCE_BITS-1:0];
         end
      end
   end

   assign cmd_next = cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= 1'b0;
         prev_ff  <= 1'b0;
         count_ff <= '0;
      end else if (update) begin
         cmd_ff   <= cmd_in;
         prev_ff  <= switch_active;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/supply_and_input_supervisor.sv]
// ----------------------------------------------------------------------------
// supply_and_input_supervisor: five channel monitors, debouncer, relay check
// A req transfer passes through the input register and the result register to
// rsp_tvalid; one tick per cycle sustained while rsp_tready is not held low.
// Synchronous reset clears config registers, fail flags and debounce state.
// ----------------------------------------------------------------------------
module supply_and_input_supervisor #(
   parameter int ADC_BITS      = sis_pkg::ADC_BITS_DEF,
   parameter int DEBOUNCE_BITS = sis_pkg::DEBOUNCE_BITS_DEF,
   localparam int FIELD_W      = sis_pkg::NUM_CH*ADC_BITS + 5 + sis_pkg::RTC_W,
   localparam int REQ_W        = ((FIELD_W + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // temp_code, battery_code, five_volt_code, relay_supply_code,
   // main_supply_code, switch_active, ac_drive, ac_feedback, dc_drive,
   // dc_feedback, rtc_seconds (lowest bit up), zero padded
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_W-1:0]                    req_tdata,
   // temp_fail, battery_fail, five_volt_fail, relay_supply_fail,
   // main_supply_fail, external_command_on, relay_ac_on, relay_dc_on,
   // relay_ac_fail, relay_dc_fail, need_service (lowest bit up), zero padded
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sis_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [sis_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [sis_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int OFS_SW   = sis_pkg::NUM_CH*ADC_BITS;
   localparam int OFS_RTC  = OFS_SW + 5;

   // configuration
   logic [sis_pkg::THR_REG_W-1:0] thr_ff [sis_pkg::NUM_CH];
   logic                          mode_ff;
   logic [sis_pkg::CSR_DATA_W-1:0] reloads_ff;
   logic [sis_pkg::RTC_W-1:0]     deadline_ff;

   // pipeline
   logic                          s1_valid_ff;
   logic [FIELD_W-1:0]            s1_data_ff;
   logic                          rsp_valid_ff;
   logic [sis_pkg::RSP_FIELD_W-1:0] rsp_data_ff;
   logic [sis_pkg::RSP_FIELD_W-1:0] rsp_data_in;
   logic                          out_free;
   logic                          advance;

   logic                          service_ff;
   logic                          service_in;
   logic [sis_pkg::NUM_CH-1:0]    fail_next;
   logic                          cmd_next;
   logic                          sw_act;
   logic                          ac_drv;
   logic                          ac_fb;
   logic                          dc_drv;
   logic                          dc_fb;
   logic [sis_pkg::RTC_W-1:0]     rtc;
   sis_pkg::dbn_cfg_type          dbn_cfg;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sis_pkg::NUM_CH; i++) begin
            thr_ff[i] <= '0;
         end
         mode_ff     <= 1'b0;
         reloads_ff  <= '0;
         deadline_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            sis_pkg::REG_TEMP_THR:      thr_ff[0] <= csr_wdata[sis_pkg::THR_REG_W-1:0];
            sis_pkg::REG_BATTERY_THR:   thr_ff[1] <= csr_wdata[sis_pkg::THR_REG_W-1:0];
            sis_pkg::REG_FIVE_VOLT_THR: thr_ff[2] <= csr_wdata[sis_pkg::THR_REG_W-1:0];
            sis_pkg::REG_RELAY_SUP_THR: thr_ff[3] <= csr_wdata[sis_pkg::THR_REG_W-1:0];
            sis_pkg::REG_MAIN_SUP_THR:  thr_ff[4] <= csr_wdata[sis_pkg::THR_REG_W-1:0];
            sis_pkg::REG_EXT_MODE:      mode_ff   <= csr_wdata[0];
            sis_pkg::REG_DEB_RELOADS:   reloads_ff <= csr_wdata;
            sis_pkg::REG_SERVICE_DL:    deadline_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata[FIELD_W-1:0];
      end
   end

   assign sw_act = s1_data_ff[OFS_SW];
   assign ac_drv = s1_data_ff[OFS_SW+1];
   assign ac_fb  = s1_data_ff[OFS_SW+2];
   assign dc_drv = s1_data_ff[OFS_SW+3];
   assign dc_fb  = s1_data_ff[OFS_SW+4];
   assign rtc    = s1_data_ff[OFS_RTC +: sis_pkg::RTC_W];

   for (genvar g = 0; g < sis_pkg::NUM_CH; g++) begin : g_chan
      sis_chan_mon #(
         .ADC_BITS (ADC_BITS)
      ) u_chan_mon (
         .clock        (clock),
         .reset        (reset),
         .update       (advance),
         .code         (s1_data_ff[g*ADC_BITS +: ADC_BITS]),
         .trip         (thr_ff[g][ADC_BITS-1:0]),
         .release_code (ADC_BITS'(thr_ff[g] >> ADC_BITS)),
         .fail_next    (fail_next[g])
      );
   end

   assign dbn_cfg.mode          = mode_ff;
   assign dbn_cfg.reload_start  = reloads_ff[sis_pkg::RELOAD_W-1:0];
   assign dbn_cfg.reload_enable = reloads_ff[2*sis_pkg::RELOAD_W-1:sis_pkg::RELOAD_W];

   // debouncer holds while the 5V rail is failing
   sis_debounce #(
      .DEBOUNCE_BITS (DEBOUNCE_BITS)
   ) u_debounce (
      .clock         (clock),
      .reset         (reset),
      .update        (advance && !fail_next[sis_pkg::FIVE_VOLT_CH]),
      .switch_active (sw_act),
      .cfg           (dbn_cfg),
      .cmd_next      (cmd_next)
   );

   assign service_in = service_ff || ((deadline_ff != '0) && (rtc > deadline_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         service_ff <= 1'b0;
      end else if (advance) begin
         service_ff <= service_in;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[sis_pkg::NUM_CH-1:0]          = fail_next;
      rsp_data_in[sis_pkg::RSP_EXT_CMD]         = cmd_next;
      rsp_data_in[sis_pkg::RSP_RELAY_AC_ON]     = ac_fb;
      rsp_data_in[sis_pkg::RSP_RELAY_DC_ON]     = dc_fb;
      rsp_data_in[sis_pkg::RSP_RELAY_AC_ERR]    = ac_fb ^ ac_drv;
      rsp_data_in[sis_pkg::RSP_RELAY_DC_ERR]    = dc_fb ^ dc_drv;
      rsp_data_in[sis_pkg::RSP_NEED_SERVICE]    = service_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sis_pkg::RSP_TDATA_W-sis_pkg::RSP_FIELD_W){1'b0}}, rsp_data_ff};

endmodule

[rtl/sis_checker.sv]
// ----------------------------------------------------------------------------
// sis_checker
// Port-level checks of the supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`include "supply_and_input_supervisor_assert.svh"

module sis_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sis_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       seen_service_ff;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         seen_service_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_xfer && rsp_tdata[sis_pkg::RSP_NEED_SERVICE]) begin
            seen_service_ff <= 1'b1;
         end
      end
   end

   `SIS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")
   `SIS_ASSERT(a_no_invented, clock, reset, rsp_xfer |-> (pending_ff != 3'd0), "result without item")
   `SIS_ASSERT(a_depth, clock, reset, pending_ff <= 3'd2, "more than two items in flight")
   `SIS_ASSERT(a_service_sticky, clock, reset, (rsp_tvalid && seen_service_ff) |-> rsp_tdata[sis_pkg::RSP_NEED_SERVICE], "need_service dropped")
   `SIS_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")

endmodule

bind supply_and_input_supervisor sis_checker u_sis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
